>>> design/radial_alpha_mask_assert.svh
// Assertion macros shared by the radial alpha mask checkers.
// Needs nothing else; take in with an include of the bare file name.
`ifndef RADIAL_ALPHA_MASK_ASSERT_SVH
`define RADIAL_ALPHA_MASK_ASSERT_SVH

// Concurrent assertion on the rising clock, disabled while reset is high.
`define RAMASK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, for a condition that must hold on every clock out of reset.
`define RAMASK_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`endif

>>> design/ramask_pkg.sv
// Package for the radial alpha mask: payload structs, widths, register map.
// Used by radial_alpha_mask and ramask_checker; depends on nothing.
package ramask_pkg;

   localparam int MAX_DIM   = 4096;
   localparam int DIM_MIN   = 2;

   localparam int COORD_W   = 12;
   localparam int DIM_W     = 13;
   localparam int RADIUS_W  = 11;
   localparam int RGB_W     = 24;
   localparam int ALPHA_W   = 8;

   localparam logic [ALPHA_W-1:0] ALPHA_FULL = 8'hFF;

   // divider stages, one quotient bit each, plus front stages and output register
   localparam int DIV_STAGES  = ALPHA_W;
   localparam int RSP_LATENCY = DIV_STAGES + 5;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_OPAQUE_RADIUS = 2'd2;

   localparam logic [DIM_W-1:0]    WIDTH_RESET  = 13'd640;
   localparam logic [DIM_W-1:0]    HEIGHT_RESET = 13'd480;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 11'd10;

   typedef struct packed {
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic [RGB_W-1:0]   pixel_rgb;
   } req_type;

   typedef struct packed {
      logic [RGB_W-1:0]   rgb_out;
      logic [ALPHA_W-1:0] alpha;
   } rsp_type;

endpackage

>>> design/radial_alpha_mask.sv
// Radial alpha mask: pipelined squared-distance vignette with restoring divider.
// Depends on ramask_pkg for payload types, widths and the register map.
//
// Usage:
//   Input channel: drive req_data and raise start; a pixel transfers at a rising
//   edge with start high and busy low. busy is low whenever reset is low, so a
//   pixel may be offered in every cycle.
//   Result channel: rsp_valid is high for exactly one cycle with rsp_data, the
//   input colour and its alpha. The receiver cannot hold results off.
//   Throughput: one pixel per clock, set by a 13-stage pipeline: four front
//   stages (clamp and offsets, squares, distance and band test, times 255)
//   and eight divider stages that each resolve one quotient bit, then the
//   output register.
//   Configuration: APB-style writes to image_width (0x0), image_height (0x4)
//   and opaque_radius (0x8), bits 1:0 not decoded; 0xC-0xF ignored on write, read 0.
//   Write registers only while no pixel is in flight.
//   Reset: synchronous, active high; clears every pipeline valid bit, restores
//   the register reset values (640, 480, 10) and holds busy high.
module radial_alpha_mask (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  ramask_pkg::req_type                 req_data,
   output logic                                rsp_valid,
   output ramask_pkg::rsp_type                 rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ramask_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ramask_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ramask_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import ramask_pkg::*;

   localparam int DSQ_W  = 24;   // one squared offset
   localparam int DIST_W = 26;   // sum of two squares
   localparam int OSQ_W  = 23;   // outer radius squared
   localparam int ISQ_W  = 22;   // opaque radius squared
   localparam int REM_W  = OSQ_W + ALPHA_W;

   typedef struct packed {
      logic             below;
      logic             above;
      logic [RGB_W-1:0] rgb;
   } side_type;

   // ---------------------------------------------------------------- registers
   logic [DIM_W-1:0]    width_ff,  width_in;
   logic [DIM_W-1:0]    height_ff, height_in;
   logic [RADIUS_W-1:0] radius_ff, radius_in;
   logic [1:0]          csr_index;
   logic                csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      radius_in = radius_ff;
      if (csr_write) begin
         case (csr_index)
            REG_IMAGE_WIDTH:   width_in  = csr_pwdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT:  height_in = csr_pwdata[DIM_W-1:0];
            REG_OPAQUE_RADIUS: radius_in = csr_pwdata[RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_IMAGE_WIDTH:   csr_prdata = {{(CSR_DATA_W-DIM_W){1'b0}}, width_ff};
         REG_IMAGE_HEIGHT:  csr_prdata = {{(CSR_DATA_W-DIM_W){1'b0}}, height_ff};
         REG_OPAQUE_RADIUS: csr_prdata = {{(CSR_DATA_W-RADIUS_W){1'b0}}, radius_ff};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         radius_ff <= RADIUS_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         radius_ff <= radius_in;
      end
   end

   assign busy = reset;

   // ------------------------------------------ stage 1: clamp, centre, offsets
   logic [DIM_W-1:0]      w_clamp, h_clamp, w_m1, h_m1, dim_min;
   logic [COORD_W-1:0]    outer_m1;
   logic                  s1_valid_ff, s1_valid_in;
   logic signed [DIM_W-1:0] s1_dx_ff, s1_dx_in, s1_dy_ff, s1_dy_in;
   logic [COORD_W-1:0]    s1_outer_ff, s1_outer_in;
   logic [RADIUS_W-1:0]   s1_inner_ff, s1_inner_in;
   logic [RGB_W-1:0]      s1_rgb_ff;

   always_comb begin
      if (width_ff < DIM_W'(DIM_MIN))       w_clamp = DIM_W'(DIM_MIN);
      else if (width_ff > DIM_W'(MAX_DIM))  w_clamp = DIM_W'(MAX_DIM);
      else                                  w_clamp = width_ff;
      if (height_ff < DIM_W'(DIM_MIN))      h_clamp = DIM_W'(DIM_MIN);
      else if (height_ff > DIM_W'(MAX_DIM)) h_clamp = DIM_W'(MAX_DIM);
      else                                  h_clamp = height_ff;
      w_m1    = w_clamp - 1'b1;
      h_m1    = h_clamp - 1'b1;
      dim_min = (w_clamp < h_clamp) ? w_clamp : h_clamp;
      s1_outer_in = dim_min[DIM_W-1:1];
      outer_m1    = s1_outer_in - 1'b1;
      s1_inner_in = ({1'b0, radius_ff} > outer_m1) ? outer_m1[RADIUS_W-1:0] : radius_ff;
      s1_dx_in = $signed({2'b00, w_m1[COORD_W-1:1]}) - $signed({1'b0, req_data.column});
      s1_dy_in = $signed({2'b00, h_m1[COORD_W-1:1]}) - $signed({1'b0, req_data.row});
      s1_valid_in = start && !busy;
   end

   // --------------------------------------------------------- stage 2: squares
   logic                    s2_valid_ff;
   logic [DSQ_W-1:0]        s2_dxsq_ff, s2_dysq_ff;
   logic [OSQ_W-1:0]        s2_outsq_ff;
   logic [ISQ_W-1:0]        s2_innsq_ff;
   logic [RGB_W-1:0]        s2_rgb_ff;
   logic signed [2*DIM_W-1:0] dxsq_full, dysq_full;
   logic [2*COORD_W-1:0]    outsq_full;
   logic [2*RADIUS_W-1:0]   innsq_full;

   always_comb begin
      dxsq_full  = s1_dx_ff * s1_dx_ff;
      dysq_full  = s1_dy_ff * s1_dy_ff;
      outsq_full = s1_outer_ff * s1_outer_ff;
      innsq_full = s1_inner_ff * s1_inner_ff;
   end

   // ---------------------------------------- stage 3: distance and band test
   logic                s3_valid_ff;
   logic [OSQ_W-1:0]    s3_num_ff, s3_num_in, s3_den_ff, s3_den_in;
   side_type            s3_side_ff, s3_side_in;
   logic [DIST_W-1:0]   dist_sq;

   always_comb begin
      dist_sq = {2'b00, s2_dxsq_ff} + {2'b00, s2_dysq_ff};
      s3_side_in.below = dist_sq < {{(DIST_W-ISQ_W){1'b0}}, s2_innsq_ff};
      s3_side_in.above = dist_sq > {{(DIST_W-OSQ_W){1'b0}}, s2_outsq_ff};
      s3_side_in.rgb   = s2_rgb_ff;
      // only meaningful inside the band, where the distance fits the outer square width
      s3_num_in = dist_sq[OSQ_W-1:0] - {1'b0, s2_innsq_ff};
      s3_den_in = s2_outsq_ff - {1'b0, s2_innsq_ff};
   end

   // --------------------------------- stage 4 and divider: (num * 255) / den
   logic                div_valid_ff [DIV_STAGES+1];
   logic [REM_W-1:0]    div_rem_ff   [DIV_STAGES+1];
   logic [OSQ_W-1:0]    div_den_ff   [DIV_STAGES+1];
   logic [ALPHA_W-1:0]  div_quo_ff   [DIV_STAGES+1];
   side_type            div_side_ff  [DIV_STAGES+1];
   logic [REM_W-1:0]    div_trial    [DIV_STAGES];
   logic                div_take     [DIV_STAGES];
   logic [REM_W-1:0]    div_rem_in   [DIV_STAGES];
   logic [REM_W-1:0]    num_x255;

   assign num_x255 = {s3_num_ff, {ALPHA_W{1'b0}}} - {{ALPHA_W{1'b0}}, s3_num_ff};

   always_comb begin
      for (int i = 0; i < DIV_STAGES; i++) begin
         // stage i resolves quotient bit DIV_STAGES-1-i
         div_trial[i]  = {{ALPHA_W{1'b0}}, div_den_ff[i]} << (DIV_STAGES - 1 - i);
         div_take[i]   = div_rem_ff[i] >= div_trial[i];
         div_rem_in[i] = div_take[i] ? (div_rem_ff[i] - div_trial[i]) : div_rem_ff[i];
      end
   end

   // ---------------------------------------------------------- output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_data_in.rgb_out = div_side_ff[DIV_STAGES].rgb;
      if (div_side_ff[DIV_STAGES].below)      rsp_data_in.alpha = ALPHA_FULL;
      else if (div_side_ff[DIV_STAGES].above) rsp_data_in.alpha = '0;
      else                                    rsp_data_in.alpha = ALPHA_FULL -
                                                                  div_quo_ff[DIV_STAGES];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------- valid bits (control)
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i <= DIV_STAGES; i++) begin
            div_valid_ff[i] <= 1'b0;
         end
      end else begin
         s1_valid_ff     <= s1_valid_in;
         s2_valid_ff     <= s1_valid_ff;
         s3_valid_ff     <= s2_valid_ff;
         div_valid_ff[0] <= s3_valid_ff;
         for (int i = 0; i < DIV_STAGES; i++) begin
            div_valid_ff[i+1] <= div_valid_ff[i];
         end
         rsp_valid_ff <= div_valid_ff[DIV_STAGES];
      end
   end

   // ------------------------------------------------ payload (no reset needed)
   always_ff @(posedge clock) begin
      s1_dx_ff    <= s1_dx_in;
      s1_dy_ff    <= s1_dy_in;
      s1_outer_ff <= s1_outer_in;
      s1_inner_ff <= s1_inner_in;
      s1_rgb_ff   <= req_data.pixel_rgb;

      s2_dxsq_ff  <= dxsq_full[DSQ_W-1:0];
      s2_dysq_ff  <= dysq_full[DSQ_W-1:0];
      s2_outsq_ff <= outsq_full[OSQ_W-1:0];
      s2_innsq_ff <= innsq_full[ISQ_W-1:0];
      s2_rgb_ff   <= s1_rgb_ff;

      s3_num_ff  <= s3_num_in;
      s3_den_ff  <= s3_den_in;
      s3_side_ff <= s3_side_in;

      div_rem_ff[0]  <= num_x255;
      div_den_ff[0]  <= s3_den_ff;
      div_quo_ff[0]  <= '0;
      div_side_ff[0] <= s3_side_ff;
      for (int i = 0; i < DIV_STAGES; i++) begin
         div_rem_ff[i+1]  <= div_rem_in[i];
         div_den_ff[i+1]  <= div_den_ff[i];
         div_quo_ff[i+1]  <= {div_quo_ff[i][ALPHA_W-2:0], div_take[i]};
         div_side_ff[i+1] <= div_side_ff[i];
      end

      if (div_valid_ff[DIV_STAGES]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> design/ramask_checker.sv
// Port-level checker for radial_alpha_mask, bound to the top level below.
// Depends on ramask_pkg and the macros in radial_alpha_mask_assert.svh.
`include "radial_alpha_mask_assert.svh"

module ramask_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input ramask_pkg::req_type req_data,
   input logic                rsp_valid,
   input ramask_pkg::rsp_type rsp_data
);
   import ramask_pkg::*;

   // every transfer in gives exactly one result after the fixed latency
   `RAMASK_ASSERT(a_rsp_follows, clock, reset, (start && !busy) |-> ##RSP_LATENCY rsp_valid, "result missing after input transfer")
   `RAMASK_ASSERT(a_rsp_has_req, clock, reset, rsp_valid |-> $past(start && !busy, RSP_LATENCY), "result without an input transfer")
   // colour passes through unchanged
   `RAMASK_ASSERT(a_rgb_kept, clock, reset, rsp_valid |-> (rsp_data.rgb_out == $past(req_data.pixel_rgb, RSP_LATENCY)), "colour changed on its way through")
   `RAMASK_ASSERT_ALWAYS(a_not_busy, clock, reset, !busy, "busy high out of reset")

endmodule

bind radial_alpha_mask ramask_checker u_ramask_checker (.*);
